### rtl/core/rhc_pkg.sv
// ----------------------------------------------------------------------------
// RGB to HSV converter package
// Beat types and arithmetic constants shared by the converter.
// ----------------------------------------------------------------------------
package rhc_pkg;

  // One pixel beat on the input channel.
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pix_in_t;

  // One result beat on the output channel.
  typedef struct packed {
    logic [14:0] hue;
    logic        hue_defined;
    logic [7:0]  saturation;
    logic [7:0]  brightness;
  } pix_out_t;

  // Hue is counted in 1/64 degree: 60 degrees per sector, 360 per turn.
  localparam int unsigned HUE_SPAN   = 3840;
  localparam int unsigned HUE_TURN   = 6 * HUE_SPAN;
  localparam int unsigned HUE_OFS_G  = 2 * HUE_SPAN;
  localparam int unsigned HUE_OFS_B  = 4 * HUE_SPAN;

  // Long division: 12 quotient bits, two per stage.
  localparam int unsigned QW         = 12;
  localparam int unsigned BITS_STAGE = 2;
  localparam int unsigned DIV_STAGES = QW / BITS_STAGE;
  localparam int unsigned NW         = 20;   // numerator and remainder width

endpackage

### rtl/core/rgb_to_hsv_converter.sv
// ----------------------------------------------------------------------------
// RGB to HSV converter
// Pipelined conversion of one 8-bit RGB pixel per clock into hue, saturation
// and brightness, with exact integer division.
// ----------------------------------------------------------------------------
//
//  Channel   Ports                      Handshake
//  -------   ------------------------   ------------------------------------
//  input     in_pixel (red,green,blue)  beat taken when start && !busy
//  output    out_pixel (hue,hue_defined,saturation,brightness)
//                                        beat valid for one cycle on out_valid
//
// A beat may enter in every clock cycle; busy is held low, as no stage ever
// has to wait. Each result passes in order through the registered stages: one
// stage sorts the channels, one forms the two numerators, six stages of
// restoring division produce two quotient bits each, and one stage applies
// the sector offset and the wrap. Reset (synchronous, rst_n low) clears only
// the valid bits of the pipeline; data in flight is discarded. The receiver
// cannot stall, so the pipeline never holds.
//
module rgb_to_hsv_converter
  import rhc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  pix_in_t  in_pixel,
  output logic     out_valid,
  output pix_out_t out_pixel
);

  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } sector_t;

  // The pipeline never stalls, so a beat is always welcome.
  assign busy = 1'b0;

  // --------------------------------------------------------------------------
  // Stage A: largest and smallest channel, sector and signed difference.
  // Ties go to red first, then green, which the order of the tests gives.
  // --------------------------------------------------------------------------
  logic [7:0]        a_hi_nxt, a_lo_nxt;
  sector_t           a_sec_nxt;
  logic signed [8:0] a_diff;
  logic              a_v_r;
  logic [7:0]        a_hi_r, a_delta_r, a_mag_r;
  sector_t           a_sec_r;
  logic              a_neg_r;

  always_comb begin
    a_hi_nxt = in_pixel.red;
    if (in_pixel.green > a_hi_nxt) a_hi_nxt = in_pixel.green;
    if (in_pixel.blue  > a_hi_nxt) a_hi_nxt = in_pixel.blue;
    a_lo_nxt = in_pixel.red;
    if (in_pixel.green < a_lo_nxt) a_lo_nxt = in_pixel.green;
    if (in_pixel.blue  < a_lo_nxt) a_lo_nxt = in_pixel.blue;

    if (in_pixel.red == a_hi_nxt) begin
      a_sec_nxt = SEC_RED;
      a_diff    = $signed({1'b0, in_pixel.green}) - $signed({1'b0, in_pixel.blue});
    end else if (in_pixel.green == a_hi_nxt) begin
      a_sec_nxt = SEC_GREEN;
      a_diff    = $signed({1'b0, in_pixel.blue}) - $signed({1'b0, in_pixel.red});
    end else begin
      a_sec_nxt = SEC_BLUE;
      a_diff    = $signed({1'b0, in_pixel.red}) - $signed({1'b0, in_pixel.green});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else begin
      a_v_r <= start && !busy;
    end
    a_hi_r    <= a_hi_nxt;
    a_delta_r <= a_hi_nxt - a_lo_nxt;
    a_sec_r   <= a_sec_nxt;
    a_neg_r   <= a_diff[8];
    a_mag_r   <= a_diff[8] ? 8'(-a_diff) : a_diff[7:0];
  end

  // --------------------------------------------------------------------------
  // Division pipeline. Entry 0 is loaded by stage B with the numerators
  // 3840*|diff| and 255*delta, both formed by shifts and a subtraction.
  // Each later entry holds the remainders after two more quotient bits.
  // --------------------------------------------------------------------------
  logic             dv_v_r    [DIV_STAGES+1];
  logic [NW-1:0]    dv_hrem_r [DIV_STAGES+1];
  logic [NW-1:0]    dv_srem_r [DIV_STAGES+1];
  logic [QW-1:0]    dv_hq_r   [DIV_STAGES+1];
  logic [QW-1:0]    dv_sq_r   [DIV_STAGES+1];
  logic [7:0]       dv_hi_r   [DIV_STAGES+1];
  logic [7:0]       dv_delta_r[DIV_STAGES+1];
  sector_t          dv_sec_r  [DIV_STAGES+1];
  logic             dv_neg_r  [DIV_STAGES+1];

  // Stage B
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_v_r[0] <= 1'b0;
    end else begin
      dv_v_r[0] <= a_v_r;
    end
    dv_hrem_r[0]  <= (NW'(a_mag_r) << 12) - (NW'(a_mag_r) << 8);
    dv_srem_r[0]  <= (NW'(a_delta_r) << 8) - NW'(a_delta_r);
    dv_hq_r[0]    <= '0;
    dv_sq_r[0]    <= '0;
    dv_hi_r[0]    <= a_hi_r;
    dv_delta_r[0] <= a_delta_r;
    dv_sec_r[0]   <= a_sec_r;
    dv_neg_r[0]   <= a_neg_r;
  end

  for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
    logic [NW-1:0] hrem_nxt, srem_nxt;
    logic [QW-1:0] hq_nxt, sq_nxt;

    // Quotient bit k is set when the remainder still covers divisor * 2^k.
    always_comb begin
      logic [NW-1:0] htrial, strial;
      hrem_nxt = dv_hrem_r[j];
      srem_nxt = dv_srem_r[j];
      hq_nxt   = dv_hq_r[j];
      sq_nxt   = dv_sq_r[j];
      for (int b = 0; b < BITS_STAGE; b++) begin
        htrial = NW'(dv_delta_r[j]) << (QW - 1 - BITS_STAGE * j - b);
        strial = NW'(dv_hi_r[j])    << (QW - 1 - BITS_STAGE * j - b);
        if (hrem_nxt >= htrial) begin
          hrem_nxt = hrem_nxt - htrial;
          hq_nxt[QW - 1 - BITS_STAGE * j - b] = 1'b1;
        end
        if (srem_nxt >= strial) begin
          srem_nxt = srem_nxt - strial;
          sq_nxt[QW - 1 - BITS_STAGE * j - b] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[j+1] <= 1'b0;
      end else begin
        dv_v_r[j+1] <= dv_v_r[j];
      end
      dv_hrem_r[j+1]  <= hrem_nxt;
      dv_srem_r[j+1]  <= srem_nxt;
      dv_hq_r[j+1]    <= hq_nxt;
      dv_sq_r[j+1]    <= sq_nxt;
      dv_hi_r[j+1]    <= dv_hi_r[j];
      dv_delta_r[j+1] <= dv_delta_r[j];
      dv_sec_r[j+1]   <= dv_sec_r[j];
      dv_neg_r[j+1]   <= dv_neg_r[j];
    end
  end

  // --------------------------------------------------------------------------
  // Final stage: sign, sector offset and wrap. Only the red sector can go
  // below zero, since the other offsets exceed one sector span. A gray pixel
  // and a black pixel have their quotients forced to zero, as the divisor
  // was zero there.
  // --------------------------------------------------------------------------
  logic [QW-1:0]      f_hq;
  logic signed [15:0] f_part, f_sum;
  pix_out_t           out_pixel_nxt;
  logic               out_valid_r;
  pix_out_t           out_pixel_r;

  always_comb begin
    f_hq   = dv_hq_r[DIV_STAGES];
    f_part = dv_neg_r[DIV_STAGES] ? -$signed({4'b0, f_hq}) : $signed({4'b0, f_hq});
    case (dv_sec_r[DIV_STAGES])
      SEC_RED:   f_sum = f_part;
      SEC_GREEN: f_sum = f_part + 16'(HUE_OFS_G);
      SEC_BLUE:  f_sum = f_part + 16'(HUE_OFS_B);
      default:   f_sum = f_part;
    endcase
    if (f_sum < 0) f_sum = f_sum + 16'(HUE_TURN);

    out_pixel_nxt.hue_defined = (dv_delta_r[DIV_STAGES] != '0);
    out_pixel_nxt.hue         = out_pixel_nxt.hue_defined ? f_sum[14:0] : '0;
    out_pixel_nxt.saturation  = (dv_hi_r[DIV_STAGES] == '0) ? '0
                                                            : dv_sq_r[DIV_STAGES][7:0];
    out_pixel_nxt.brightness  = dv_hi_r[DIV_STAGES];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= dv_v_r[DIV_STAGES];
    end
    out_pixel_r <= out_pixel_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_pixel = out_pixel_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_pixel.hue < 15'(HUE_TURN)))
    else $error("hue beyond one full turn");

  a_gray_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_pixel.hue_defined) |->
      (out_pixel.hue == '0 && out_pixel.saturation == '0))
    else $error("gray pixel with nonzero hue or saturation");

  a_defined_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_pixel.hue_defined) |-> (out_pixel.saturation != '0))
    else $error("coloured pixel with zero saturation");

  a_sat_bright: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_pixel.saturation != '0) |->
      (out_pixel.brightness != '0 && out_pixel.hue_defined))
    else $error("saturation without brightness or hue");

endmodule

### sim/tb_rgb_to_hsv_converter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB to HSV converter testbench
// Drives pixel beats into the converter with random gaps, computes the
// expected hue, saturation and brightness of each pixel in exact integer
// arithmetic, and compares every result beat field by field in order.
// ----------------------------------------------------------------------------
module tb_rgb_to_hsv_converter
  import rhc_pkg::*;
();

  // Signed copies of the hue constants. The package gives them as unsigned,
  // and mixing those with negative differences would turn the whole
  // expression unsigned.
  localparam int SECTOR    = HUE_SPAN;
  localparam int FULL_TURN = HUE_TURN;
  localparam int OFS_GREEN = HUE_OFS_G;
  localparam int OFS_BLUE  = HUE_OFS_B;

  // A gap with no beat on either channel longer than this means the block has hung.
  localparam int STALL_LIMIT = 1000;
  // Settling time after the last result, comfortably above the pipeline depth.
  localparam int DRAIN_CYCLES = 20;
  // Once this few pixels remain to be sent, the sender stops idling.
  localparam int CALM_TAIL = 150;

  typedef struct {
    pix_in_t  src;
    pix_out_t want;
  } hsv_expect_t;

  logic     clk;
  logic     rst_n;
  logic     start;
  logic     busy;
  pix_in_t  in_pixel;
  logic     out_valid;
  pix_out_t out_pixel;

  pix_in_t     pending_pixels[$];
  hsv_expect_t hsv_expected[$];

  int  total_pixels;
  int  pixels_sent;
  int  results_seen;
  int  errors;
  int  gray_count;
  int  red_count;
  int  green_count;
  int  blue_count;
  int  gap_left;
  int  idle_cycles;
  bit  beat_taken;

  rgb_to_hsv_converter dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_pixel  (in_pixel),
    .out_valid (out_valid),
    .out_pixel (out_pixel)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Exact integer conversion of one pixel. Division in SystemVerilog on
  // signed ints truncates toward zero, which is what the hue formula needs.
  function automatic pix_out_t predict_hsv(pix_in_t p);
    int r;
    int g;
    int b;
    int hi;
    int lo;
    int delta;
    int h;
    pix_out_t o;
    r = p.red;
    g = p.green;
    b = p.blue;
    hi = r;
    if (g > hi) hi = g;
    if (b > hi) hi = b;
    lo = r;
    if (g < lo) lo = g;
    if (b < lo) lo = b;
    delta = hi - lo;
    o = '0;
    o.brightness = 8'(hi);
    if (hi != 0) o.saturation = 8'((255 * delta) / hi);
    if (delta != 0) begin
      o.hue_defined = 1'b1;
      // Ties for the largest channel go to red first, then green.
      if (r == hi) h = (SECTOR * (g - b)) / delta;
      else if (g == hi) h = OFS_GREEN + (SECTOR * (b - r)) / delta;
      else h = OFS_BLUE + (SECTOR * (r - g)) / delta;
      if (h < 0) h += FULL_TURN;
      o.hue = 15'(h);
    end
    return o;
  endfunction

  task automatic report_mismatch(string field, int got, int want, pix_in_t src);
    $display("[%0t] HSV error on %s: got %0d, expected %0d (pixel r=%0d g=%0d b=%0d)",
             $realtime, field, got, want, src.red, src.green, src.blue);
    errors++;
  endtask

  function automatic pix_in_t mk_pixel(int r, int g, int b);
    pix_in_t p;
    p.red   = 8'(r);
    p.green = 8'(g);
    p.blue  = 8'(b);
    return p;
  endfunction

  // Random pixel with a bias towards the corners of the conversion: grays,
  // ties for the largest channel, tiny spreads and dark pixels all take
  // different paths through the sector choice and the divisions.
  function automatic pix_in_t random_pixel();
    int v;
    int w;
    pix_in_t p;
    v = $urandom_range(0, 255);
    w = $urandom_range(0, 255);
    case ($urandom_range(0, 9))
      0: p = mk_pixel(v, v, v);
      1: p = mk_pixel(v, v, w);
      2: p = mk_pixel(w, v, v);
      3: p = mk_pixel(v, w, v);
      4: begin
        // Spread of at most two between the channels, or a wrap past 255.
        p = mk_pixel(v, (v + $urandom_range(0, 2)) % 256, (v + $urandom_range(0, 2)) % 256);
      end
      5: p = mk_pixel($urandom_range(0, 3), $urandom_range(0, 3), $urandom_range(0, 3));
      default: p = pix_in_t'($urandom());
    endcase
    return p;
  endfunction

  // Stimulus, reset and the end of the run.
  initial begin
    rst_n    = 1'b0;
    start    = 1'b0;
    in_pixel = '0;

    // Directed pixels: black, white, a mid gray, the primaries and
    // secondaries, every kind of tie for the largest channel, hue values
    // that go negative and wrap, the smallest non-zero brightness, and
    // alternating bit patterns.
    pending_pixels.push_back(mk_pixel(0, 0, 0));
    pending_pixels.push_back(mk_pixel(255, 255, 255));
    pending_pixels.push_back(mk_pixel(128, 128, 128));
    pending_pixels.push_back(mk_pixel(255, 0, 0));
    pending_pixels.push_back(mk_pixel(0, 255, 0));
    pending_pixels.push_back(mk_pixel(0, 0, 255));
    pending_pixels.push_back(mk_pixel(255, 255, 0));
    pending_pixels.push_back(mk_pixel(0, 255, 255));
    pending_pixels.push_back(mk_pixel(255, 0, 255));
    pending_pixels.push_back(mk_pixel(255, 0, 1));
    pending_pixels.push_back(mk_pixel(255, 254, 255));
    pending_pixels.push_back(mk_pixel(1, 0, 0));
    pending_pixels.push_back(mk_pixel(0, 0, 1));
    pending_pixels.push_back(mk_pixel(1, 1, 0));
    pending_pixels.push_back(mk_pixel(255, 254, 254));
    pending_pixels.push_back(mk_pixel(254, 255, 0));
    pending_pixels.push_back(mk_pixel(128, 0, 255));
    pending_pixels.push_back(mk_pixel(255, 1, 0));
    pending_pixels.push_back(mk_pixel(8'hAA, 8'h55, 8'hAA));
    pending_pixels.push_back(mk_pixel(8'h55, 8'hAA, 8'h55));
    pending_pixels.push_back(mk_pixel(1, 2, 3));
    pending_pixels.push_back(mk_pixel(3, 2, 1));
    repeat (1000) pending_pixels.push_back(random_pixel());
    total_pixels = pending_pixels.size();

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // The watchdog ends the run if any of these waits never completes.
    while (pixels_sent != total_pixels) @(posedge clk);
    while (hsv_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d pixels and checked %0d results.", pixels_sent, results_seen);
    $display("Of these %0d gray, %0d red, %0d green and %0d blue sector.",
             gray_count, red_count, green_count, blue_count);
    if (errors == 0) begin
      $display("rgb_to_hsv_converter: match");
    end else begin
      $display("rgb_to_hsv_converter: mismatch");
    end
    $finish;
  end

  // Driver: changes the inputs on the falling edge. A beat stays on the port
  // until the monitor has seen it taken; idle bursts are only inserted
  // between beats, and alternate stretches of a hundred pixels run without
  // any idling at all. The tail of the run is sent back to back.
  always @(negedge clk) begin
    if (rst_n) begin
      if (!start || beat_taken) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          start    <= 1'b0;
        end else if (pending_pixels.size() != 0) begin
          if (pending_pixels.size() > CALM_TAIL && ((pending_pixels.size() / 100) % 2 == 0)
              && $urandom_range(0, 5) == 0) begin
            gap_left <= $urandom_range(1, 19) - 1;
            start    <= 1'b0;
          end else begin
            start    <= 1'b1;
            in_pixel <= pending_pixels.pop_front();
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: samples both channels on the rising edge. Accepted pixels are
  // turned into expectations first, so a result is only ever matched
  // against a pixel that has already gone in.
  always @(posedge clk) begin
    hsv_expect_t e;
    pix_out_t    pred;
    if (rst_n) begin
      if (start && !busy) begin
        pred   = predict_hsv(in_pixel);
        e.src  = in_pixel;
        e.want = pred;
        hsv_expected.push_back(e);
        pixels_sent++;
        beat_taken <= 1'b1;
        if (!pred.hue_defined) gray_count++;
        else if (pred.hue < OFS_GREEN - SECTOR || pred.hue >= FULL_TURN - SECTOR) red_count++;
        else if (pred.hue < OFS_BLUE - SECTOR) green_count++;
        else blue_count++;
      end else begin
        beat_taken <= 1'b0;
      end
      if (out_valid) begin
        results_seen++;
        if (hsv_expected.size() == 0) begin
          report_mismatch("unexpected result", out_pixel.hue, 0, pix_in_t'('0));
        end else begin
          e = hsv_expected.pop_front();
          if (out_pixel.hue !== e.want.hue)
            report_mismatch("hue", out_pixel.hue, e.want.hue, e.src);
          if (out_pixel.hue_defined !== e.want.hue_defined)
            report_mismatch("hue_defined", out_pixel.hue_defined, e.want.hue_defined, e.src);
          if (out_pixel.saturation !== e.want.saturation)
            report_mismatch("saturation", out_pixel.saturation, e.want.saturation, e.src);
          if (out_pixel.brightness !== e.want.brightness)
            report_mismatch("brightness", out_pixel.brightness, e.want.brightness, e.src);
        end
      end
    end else begin
      beat_taken <= 1'b0;
    end
  end

  // Watchdog: counts cycles in which neither channel moves a beat.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Timed out after %0d cycles without a beat.", STALL_LIMIT);
      $display("rgb_to_hsv_converter: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

### filelist.f
rtl/core/rhc_pkg.sv
rtl/core/rgb_to_hsv_converter.sv
sim/tb_rgb_to_hsv_converter.sv
